// ===== hw/rtl/mmu_pkg.sv =====
// Shared types, constants and helpers of the matrix multiply unit.
`default_nettype none

package mmu_pkg;

  localparam int MAX_DIM   = 8;
  localparam int FRAC_BITS = 16;

  localparam int DATA_W = 32;
  localparam int DIM_W  = 4;
  localparam int ROW_W  = 3;
  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
  localparam int ACC_W  = 2 * DATA_W + IDX_W;
  localparam int PROD_W = 2 * DATA_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int OUT_DEPTH = 4;
  localparam int OPTR_W    = $clog2(OUT_DEPTH);
  localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] MODE_LOAD_A  = 2'd0;
  localparam logic [1:0] MODE_LOAD_B  = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS     = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd3;

  typedef enum logic [1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   col;
    logic [DATA_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0] a_rows;
    logic [DIM_W-1:0] inner_size;
    logic [DIM_W-1:0] b_cols;
  } dims_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [ROW_W-1:0] r,
                                                 input logic [ROW_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/matrix_multiply_unit.sv =====
// Top level of the fixed-point matrix multiply unit.
// Input channel (in_valid/in_ready) carries requests: mode 0 writes one A
// element, mode 1 one B element, mode 2 computes A x B; mode 3 and loads at
// out-of-range indices are taken and dropped. Sizes come from the cfg port
// (index 0 a_rows, 1 inner_size, 2 b_cols; values above 8 act as 8), to be
// written only while the unit is idle; the block itself does not enforce this.
// Output channel (out_valid/out_ready) returns one result per product
// position in row-major order, last_result set on the final one. Values are
// Q16.16, summed exactly, rounded half up and saturated.
// Loads leave the queue back to back while the back end is idle, limited by
// the single write port of each element store. A compute holds the back end
// until every product position is issued: one multiply-accumulate unit
// handles one product term per cycle, pausing at the start of a position
// while no result slot is free.
// A four-entry command queue decouples the input from the back end, so loads
// keep flowing while a compute finishes draining.
// When the receiver stalls, four result slots fill and the sequencer waits
// for a free slot; the input queue then fills and in_ready drops.
// Reset: queues and pipeline empty, sizes back to 3 x 3 x 3. Element stores
// are not cleared; read only elements that have been written.
`default_nettype none

module matrix_multiply_unit
  import mmu_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           mode,
  input  wire logic [ROW_W-1:0]     row_index,
  input  wire logic [ROW_W-1:0]     col_index,
  input  wire logic [DATA_W-1:0]    element_value,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [ROW_W-1:0]          out_row,
  output logic [ROW_W-1:0]          out_col,
  output logic [DATA_W-1:0]         product_value,
  output logic                      last_result,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data
);

  dims_t dims;
  logic  q_full, q_push, q_head_valid, q_pop;
  cmd_t  q_push_cmd, q_head;

  // Size registers; writes to unused indexes fall through.
  always_ff @(posedge clk) begin
    if (rst) begin
      dims.a_rows     <= DIM_RESET;
      dims.inner_size <= DIM_RESET;
      dims.b_cols     <= DIM_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_A_ROWS:     dims.a_rows     <= cfg_data;
        REG_INNER_SIZE: dims.inner_size <= cfg_data;
        REG_B_COLS:     dims.b_cols     <= cfg_data;
        default: ;
      endcase
    end
  end

  mmu_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .row_index     (row_index),
    .col_index     (col_index),
    .element_value (element_value),
    .q_full        (q_full),
    .push          (q_push),
    .push_cmd      (q_push_cmd)
  );

  mmu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  mmu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .dims          (dims),
    .head_valid    (q_head_valid),
    .head          (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row       (out_row),
    .out_col       (out_col),
    .product_value (product_value),
    .last_result   (last_result)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/mmu_front.sv =====
// Front end: takes input requests, drops ignored ones, classifies the rest.
`default_nettype none

module mmu_front
  import mmu_pkg::*;
(
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        mode,
  input  wire logic [ROW_W-1:0]  row_index,
  input  wire logic [ROW_W-1:0]  col_index,
  input  wire logic [DATA_W-1:0] element_value,
  input  wire logic              q_full,
  output logic                   push,
  output cmd_t                   push_cmd
);

  logic in_range;
  logic keep;

  assign in_ready = !q_full;
  assign in_range = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);

  always_comb begin
    push_cmd.row   = row_index;
    push_cmd.col   = col_index;
    push_cmd.value = element_value;
    push_cmd.kind  = CMD_COMPUTE;
    keep           = 1'b0;
    unique case (mode)
      MODE_LOAD_A: begin
        push_cmd.kind = CMD_LOAD_A;
        keep          = in_range;
      end
      MODE_LOAD_B: begin
        push_cmd.kind = CMD_LOAD_B;
        keep          = in_range;
      end
      MODE_COMPUTE: begin
        push_cmd.kind = CMD_COMPUTE;
        keep          = 1'b1;
      end
      default: begin
        keep = 1'b0;  // unused mode: accepted and dropped
      end
    endcase
  end

  assign push = in_valid && in_ready && keep;

endmodule

`default_nettype wire

// ===== hw/rtl/mmu_queue.sv =====
// Command queue between the front end and the compute back end.
`default_nettype none

module mmu_queue
  import mmu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  output logic      head_valid,
  output cmd_t      head,
  input  wire logic pop
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mmu_back.sv =====
// Back end: element stores, position sequencer, MAC pipeline and result buffer.
`default_nettype none

module mmu_back
  import mmu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dims_t             dims,
  input  wire logic              head_valid,
  input  wire cmd_t              head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ROW_W-1:0]       out_row,
  output logic [ROW_W-1:0]       out_col,
  output logic [DATA_W-1:0]      product_value,
  output logic                   last_result
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             first;
    logic             last_k;
    logic             last_res;
    logic             zero;
  } beat_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic              last;
  } result_t;

  localparam logic [ACC_W-1:0] ROUND_ADD = (ACC_W'(1) << FRAC_BITS) >> 1;

  state_t state, state_next;

  logic [DATA_W-1:0] a_mem [MAX_DIM * MAX_DIM];
  logic [DATA_W-1:0] b_mem [MAX_DIM * MAX_DIM];

  logic [IDX_W-1:0] ci, cj, ck;
  logic [IDX_W-1:0] rows_m1, cols_m1, inner_m1;
  logic             inner_zero;

  logic [DIM_W-1:0] rows_c, cols_c, inner_c;
  logic             last_i, last_j, last_k;
  logic             credit_ok, issue, pos_start;

  logic [OCNT_W-1:0] pending;

  logic signed [DATA_W-1:0] rd_a, rd_b;
  logic                     s1_valid, s2_valid, s3_valid;
  beat_t                    s1, s2, s3;
  logic signed [PROD_W-1:0] s2_prod;
  logic [ACC_W-1:0]         acc;

  logic [ACC_W-1:0]         rounded;
  logic signed [ACC_W-1:0]  shifted;
  logic [DATA_W-1:0]        sat_value;
  logic                     fits;

  result_t           obuf [OUT_DEPTH];
  logic [OPTR_W-1:0] owr, ord;
  logic [OCNT_W-1:0] ocount;
  logic              opop;

  assign rows_c  = clamp_dim(dims.a_rows);
  assign cols_c  = clamp_dim(dims.b_cols);
  assign inner_c = clamp_dim(dims.inner_size);

  assign last_i = (ci == rows_m1);
  assign last_j = (cj == cols_m1);
  assign last_k = (ck == inner_m1);

  assign credit_ok = (pending < OCNT_W'(OUT_DEPTH));
  assign issue     = (state == ST_RUN) && ((ck != '0) || credit_ok);
  assign pos_start = issue && (ck == '0);

  // Queue head is taken only between runs, so loads never overtake compute reads.
  assign pop = (state == ST_IDLE) && head_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (head_valid && head.kind == CMD_COMPUTE &&
            rows_c != '0 && cols_c != '0) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue && last_k && last_j && last_i) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ci    <= '0;
      cj    <= '0;
      ck    <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        ci <= '0;
        cj <= '0;
        ck <= '0;
      end else if (issue) begin
        if (last_k) begin
          ck <= '0;
          if (last_j) begin
            cj <= '0;
            ci <= ci + IDX_W'(1);
          end else begin
            cj <= cj + IDX_W'(1);
          end
        end else begin
          ck <= ck + IDX_W'(1);
        end
      end
    end
  end

  // Run sizes are sampled when a compute leaves the queue.
  always_ff @(posedge clk) begin
    if (pop && head.kind == CMD_COMPUTE) begin
      rows_m1    <= IDX_W'(rows_c - DIM_W'(1));
      cols_m1    <= IDX_W'(cols_c - DIM_W'(1));
      inner_m1   <= (inner_c == '0) ? '0 : IDX_W'(inner_c - DIM_W'(1));
      inner_zero <= (inner_c == '0);
    end
  end

  // Element stores: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (pop && head.kind == CMD_LOAD_A) begin
      a_mem[mem_addr(head.row, head.col)] <= head.value;
    end
    rd_a <= a_mem[mem_addr(ROW_W'(ci), ROW_W'(ck))];
  end

  always_ff @(posedge clk) begin
    if (pop && head.kind == CMD_LOAD_B) begin
      b_mem[mem_addr(head.row, head.col)] <= head.value;
    end
    rd_b <= b_mem[mem_addr(ROW_W'(ck), ROW_W'(cj))];
  end

  // MAC pipeline: read, multiply, accumulate.
  always_ff @(posedge clk) begin
    s1.row      <= ci;
    s1.col      <= cj;
    s1.first    <= (ck == '0);
    s1.last_k   <= last_k;
    s1.last_res <= last_i && last_j;
    s1.zero     <= inner_zero;
    s2          <= s1;
    if (s1.zero) begin
      s2_prod <= '0;
    end else begin
      s2_prod <= rd_a * rd_b;
    end
    if (s2_valid) begin
      s3 <= s2;
      if (s2.first) begin
        acc <= {{(ACC_W-PROD_W){s2_prod[PROD_W-1]}}, s2_prod};
      end else begin
        acc <= acc + {{(ACC_W-PROD_W){s2_prod[PROD_W-1]}}, s2_prod};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid && s2.last_k;
    end
  end

  // Round half up, then saturate to the element range.
  always_comb begin
    rounded = acc + ROUND_ADD;
    shifted = $signed(rounded) >>> FRAC_BITS;
    fits    = (&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]);
    if (fits) begin
      sat_value = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat_value = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // Result buffer; a position starts only when its slot is reserved.
  assign out_valid     = (ocount != '0);
  assign opop          = out_valid && out_ready;
  assign out_row       = obuf[ord].row;
  assign out_col       = obuf[ord].col;
  assign product_value = obuf[ord].value;
  assign last_result   = obuf[ord].last;

  always_ff @(posedge clk) begin
    if (s3_valid) begin
      obuf[owr].row   <= ROW_W'(s3.row);
      obuf[owr].col   <= ROW_W'(s3.col);
      obuf[owr].value <= sat_value;
      obuf[owr].last  <= s3.last_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr     <= '0;
      ord     <= '0;
      ocount  <= '0;
      pending <= '0;
    end else begin
      if (s3_valid) begin
        owr <= owr + OPTR_W'(1);
      end
      if (opop) begin
        ord <= ord + OPTR_W'(1);
      end
      ocount  <= ocount + OCNT_W'(s3_valid) - OCNT_W'(opop);
      pending <= pending + OCNT_W'(pos_start) - OCNT_W'(opop);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mmu_checker.sv =====
// Port-level checks for the matrix multiply unit, bound to the top level.
`default_nettype none

module mmu_checker
  import mmu_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [ROW_W-1:0]     out_row,
  input wire logic [ROW_W-1:0]     out_col,
  input wire logic [DATA_W-1:0]    product_value,
  input wire logic                 last_result,
  input wire logic                 cfg_write,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [DIM_W-1:0]     cfg_data
);

  logic [DIM_W-1:0] a_rows_q, b_cols_q;
  logic             a_rows_ok, b_cols_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows_q <= DIM_RESET;
      b_cols_q <= DIM_RESET;
    end else if (cfg_write && cfg_index == REG_A_ROWS) begin
      a_rows_q <= cfg_data;
    end else if (cfg_write && cfg_index == REG_B_COLS) begin
      b_cols_q <= cfg_data;
    end
  end

  assign a_rows_ok = (a_rows_q != '0) && (a_rows_q <= DIM_W'(MAX_DIM));
  assign b_cols_ok = (b_cols_q != '0) && (b_cols_q <= DIM_W'(MAX_DIM));

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_row) && $stable(out_col) &&
      $stable(product_value) && $stable(last_result))
    else $error("result payload changed while stalled");

  // Coming out of reset: nothing buffered, queue has room.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("unit not empty after reset");

  // The final result of a run sits at the corner of the product.
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_result && a_rows_ok && b_cols_ok |->
      ({1'b0, out_row} == DIM_W'(a_rows_q - DIM_W'(1))) &&
      ({1'b0, out_col} == DIM_W'(b_cols_q - DIM_W'(1))))
    else $error("last result not at final position");

endmodule

bind matrix_multiply_unit mmu_checker u_mmu_checker (.*);

`default_nettype wire
